>>> rtl/gpw_pkg.sv
package gpw_pkg;

    localparam int CW       = 32;
    localparam int DXW      = 33;
    localparam int PRW      = 66;
    localparam int AW       = 67;
    localparam int DW       = 104;
    localparam int VW       = 104;
    localparam int QW       = 140;
    localparam int NUMW     = QW + 8;
    localparam int QMW      = 34;
    localparam int T1W      = 42;
    localparam int LW       = 48;
    localparam int LHW      = 38;
    localparam int NRMW     = 128;
    localparam int MSW      = 7;
    localparam int FRW      = 30;
    localparam int MANW     = 31;
    localparam int TRW      = 33;
    localparam int XW       = 32;
    localparam int SUMW     = 34;
    localparam int NW       = 8;
    localparam int WW       = 64;
    localparam int NTERM    = 12;
    localparam int CFG_IW   = 3;
    localparam int COV_WAIT = 48;
    localparam int WAIT_W   = $clog2(COV_WAIT + 1);

    localparam logic [27:0]          LOG2E_HALF = 28'd193635251;
    localparam logic [XW-1:0]        LN2_FRAC   = 32'd2977044472;
    localparam logic signed [LW-1:0] KCONST     = 48'sd85997081362;

    typedef enum logic [CFG_IW-1:0] {
        CFG_XX,
        CFG_XY,
        CFG_XT,
        CFG_YY,
        CFG_YT,
        CFG_TT
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] particle_x;
        logic signed [CW-1:0] particle_y;
        logic signed [CW-1:0] particle_heading;
        logic signed [CW-1:0] ref_x;
        logic signed [CW-1:0] ref_y;
        logic signed [CW-1:0] ref_heading;
    } gpw_req_t;

    typedef struct packed {
        logic [WW-1:0] weight;
        logic          singular;
        logic          saturated;
    } gpw_rsp_t;

    typedef struct packed {
        logic [5:0][AW-1:0] adj;
        logic [DW-1:0]      det;
        logic [LHW-1:0]     lhd;
        logic               singular;
    } gpw_cov_t;

    // Maps a symmetric 3x3 position onto the six stored adjugate entries.
    function automatic int adj_sel(input int r, input int c);
        int lo;
        int hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        if (lo == 0)
        begin
            return hi;
        end
        else if (lo == 1)
        begin
            return hi + 2;
        end
        return 5;
    endfunction

endpackage

>>> rtl/gaussian_pose_weight_3d_top.sv
// Channel   Handshake                 Payload
// request   start / busy              request (particle and reference pose)
// result    done, one cycle           result (weight, singular, saturated)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request is taken in every cycle that start is high and busy is low, and each is answered with done.
// The result passes through the 34-stage divider and the 36-stage exponential series.
// After reset and after every register write, busy stays high while the
// determinant, adjugate and log2 of the determinant are recomputed.
// The pipeline never stalls; each result is shown for one cycle with done.
module gaussian_pose_weight_3d_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  gpw_pkg::gpw_req_t           request,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gpw_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [gpw_pkg::CW-1:0]      cfg_data,
    output logic                        done,
    output gpw_pkg::gpw_rsp_t           result
);
    import gpw_pkg::*;

    localparam int FRONT_LAT = 8;

    gpw_cov_t              cov;
    logic [WAIT_W-1:0]     wait_reg;
    logic                  accept;
    logic signed [AW-1:0]  adj_s [6];
    logic signed [DXW-1:0] d_reg [3];
    logic [3*DXW-1:0]      dd_bits;
    logic signed [DXW-1:0] dd_s [3];
    logic signed [AW+DXW-1:0] vp [3][3];
    logic signed [VW-1:0]  v_reg [3];
    logic signed [VW+DXW-1:0] qp [3];
    logic signed [QW-1:0]  qn_reg;
    logic [QW-1:0]         mag;
    logic [NUMW-1:0]       num_reg;
    logic                  qneg_reg;
    logic                  num_vld;
    logic                  q_vld, q_neg;
    logic [QMW-1:0]        qm;
    logic                  e_vld, e_sat;
    logic [WW-1:0]         e_weight;
    gpw_rsp_t              result_reg;
    logic                  done_reg;

    assign cfg_ready = 1'b1;
    assign busy      = wait_reg != '0;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= WAIT_W'(COV_WAIT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            wait_reg <= WAIT_W'(COV_WAIT);
        end
        else if (wait_reg != '0)
        begin
            wait_reg <= wait_reg - WAIT_W'(1);
        end
    end

    gpw_cov u_cov (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cov      (cov)
    );

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            adj_s[k] = $signed(cov.adj[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= DXW'(request.particle_x) - DXW'(request.ref_x);
        d_reg[1] <= DXW'(request.particle_y) - DXW'(request.ref_y);
        d_reg[2] <= DXW'(request.particle_heading) - DXW'(request.ref_heading);
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            gpw_mul #(.WA(AW), .WB(DXW)) u_vm (
                .clk (clk),
                .a   (adj_s[3'(adj_sel(r, c))]),
                .b   (d_reg[c]),
                .p   (vp[r][c])
            );
        end
        gpw_mul #(.WA(VW), .WB(DXW)) u_qm (
            .clk (clk),
            .a   (v_reg[r]),
            .b   (dd_s[r]),
            .p   (qp[r])
        );
        assign dd_s[r] = $signed(dd_bits[(2-r)*DXW +: DXW]);
    end

    gpw_dly #(.W(3 * DXW), .N(3)) u_ddly (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({d_reg[0], d_reg[1], d_reg[2]}),
        .dout  (dd_bits)
    );

    gpw_dly #(.W(1), .N(FRONT_LAT)) u_vdly (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (accept),
        .dout  (num_vld)
    );

    assign mag = qn_reg[QW-1] ? QW'(-qn_reg) : QW'(qn_reg);

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            v_reg[r] <= VW'(vp[r][0]) + VW'(vp[r][1]) + VW'(vp[r][2]);
        end
        qn_reg   <= QW'(qp[0]) + QW'(qp[1]) + QW'(qp[2]);
        qneg_reg <= qn_reg[QW-1];
        num_reg  <= {mag, 8'd0};
    end

    gpw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (num_vld),
        .num      (num_reg),
        .qneg     (qneg_reg),
        .det      (cov.det),
        .out_vld  (q_vld),
        .qm       (qm),
        .qneg_out (q_neg)
    );

    gpw_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (q_vld),
        .qm        (qm),
        .qneg      (q_neg),
        .lhd       (cov.lhd),
        .out_vld   (e_vld),
        .weight    (e_weight),
        .saturated (e_sat)
    );

    always_ff @(posedge clk)
    begin
        result_reg.weight    <= cov.singular ? '0 : e_weight;
        result_reg.singular  <= cov.singular;
        result_reg.saturated <= !cov.singular && e_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= e_vld;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/gpw_dly.sv
module gpw_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

>>> rtl/gpw_mul.sv
module gpw_mul #(
    parameter int WA = 64,
    parameter int WB = 33
) (
    input  logic                  clk,
    input  logic signed [WA-1:0]  a,
    input  logic signed [WB-1:0]  b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NCH = (WA + 31) / 32;
    localparam int PPW = WB + 33;
    localparam int SW  = NCH * 32 + WB + 1;

    logic signed [NCH*32-1:0] a_ext;
    logic signed [PPW-1:0]    pp_reg [NCH];
    logic signed [SW-1:0]     acc;
    logic signed [WA+WB-1:0]  p_reg;

    assign a_ext = (NCH*32)'(a);

    // The low slices are unsigned, the top slice carries the sign.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NCH; k++)
        begin
            if (k == NCH - 1)
            begin
                pp_reg[k] <= $signed(a_ext[k*32 +: 32]) * b;
            end
            else
            begin
                pp_reg[k] <= $signed({1'b0, a_ext[k*32 +: 32]}) * b;
            end
        end
        p_reg <= acc[WA+WB-1:0];
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < NCH; k++)
        begin
            acc = acc + (SW'(pp_reg[k]) <<< (32 * k));
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/gpw_cov.sv
module gpw_cov (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [gpw_pkg::CFG_IW-1:0]   wr_index,
    input  logic [gpw_pkg::CW-1:0]       wr_data,
    output gpw_pkg::gpw_cov_t            cov
);
    import gpw_pkg::*;

    logic [CW-1:0] cxx_reg, cxy_reg, cxt_reg, cyy_reg, cyt_reg, ctt_reg;
    logic signed [DXW-1:0] sa, sb, sc, se, sf, sg;
    logic signed [PRW-1:0] pr_reg [12];
    logic signed [AW-1:0]  adj_reg [6];
    logic signed [AW+DXW-1:0] dp [3];
    logic [DW-1:0]   det_reg;
    logic [NRMW-1:0] nrm_reg [8];
    logic [MSW-1:0]  lz_reg [8];
    logic [MANW-1:0] y_reg [FRW+1];
    logic [FRW-1:0]  fr_reg [FRW+1];
    logic [MSW-1:0]  ms_reg [FRW+1];
    logic [LHW-1:0]  lhd_reg;
    logic [MANW:0]   sq_w [FRW];

    function automatic logic [MANW:0] sq_step(input logic [MANW-1:0] y);
        logic [2*MANW-1:0] p;
        logic [MANW:0]     s;
        p = (2*MANW)'(y) * (2*MANW)'(y);
        s = p[2*MANW-1:MANW-1];
        return s[MANW] ? {1'b1, s[MANW:1]} : {1'b0, s[MANW-1:0]};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cxx_reg <= 32'd65536;
            cxy_reg <= '0;
            cxt_reg <= '0;
            cyy_reg <= 32'd65536;
            cyt_reg <= '0;
            ctt_reg <= 32'd65536;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_XX: cxx_reg <= wr_data;
                CFG_XY: cxy_reg <= wr_data;
                CFG_XT: cxt_reg <= wr_data;
                CFG_YY: cyy_reg <= wr_data;
                CFG_YT: cyt_reg <= wr_data;
                CFG_TT: ctt_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign sa = $signed({1'b0, cxx_reg});
    assign sb = $signed({cxy_reg[CW-1], cxy_reg});
    assign sc = $signed({cxt_reg[CW-1], cxt_reg});
    assign se = $signed({1'b0, cyy_reg});
    assign sf = $signed({cyt_reg[CW-1], cyt_reg});
    assign sg = $signed({1'b0, ctt_reg});

    always_ff @(posedge clk)
    begin
        pr_reg[0]  <= se * sg;
        pr_reg[1]  <= sf * sf;
        pr_reg[2]  <= sc * sf;
        pr_reg[3]  <= sb * sg;
        pr_reg[4]  <= sb * sf;
        pr_reg[5]  <= sc * se;
        pr_reg[6]  <= sa * sg;
        pr_reg[7]  <= sc * sc;
        pr_reg[8]  <= sb * sc;
        pr_reg[9]  <= sa * sf;
        pr_reg[10] <= sa * se;
        pr_reg[11] <= sb * sb;
        for (int k = 0; k < 6; k++)
        begin
            adj_reg[k] <= AW'(pr_reg[2*k]) - AW'(pr_reg[2*k+1]);
        end
    end

    gpw_mul #(.WA(AW), .WB(DXW)) u_det0 (.clk(clk), .a(adj_reg[0]), .b(sa), .p(dp[0]));
    gpw_mul #(.WA(AW), .WB(DXW)) u_det1 (.clk(clk), .a(adj_reg[1]), .b(sb), .p(dp[1]));
    gpw_mul #(.WA(AW), .WB(DXW)) u_det2 (.clk(clk), .a(adj_reg[2]), .b(sc), .p(dp[2]));

    always_comb
    begin
        for (int j = 0; j < FRW; j++)
        begin
            sq_w[j] = sq_step(y_reg[j]);
        end
    end

    // The log2 of the determinant: leading-zero search in binary steps, then
    // one squaring per fraction bit.
    always_ff @(posedge clk)
    begin
        det_reg    <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
        nrm_reg[0] <= NRMW'(det_reg);
        lz_reg[0]  <= '0;
        for (int s = 1; s < 8; s++)
        begin
            if ((nrm_reg[s-1] >> (NRMW - (1 << (7 - s)))) == '0)
            begin
                nrm_reg[s] <= nrm_reg[s-1] << (1 << (7 - s));
                lz_reg[s]  <= lz_reg[s-1] | MSW'(1 << (7 - s));
            end
            else
            begin
                nrm_reg[s] <= nrm_reg[s-1];
                lz_reg[s]  <= lz_reg[s-1];
            end
        end
        y_reg[0]  <= nrm_reg[7][NRMW-1 -: MANW];
        ms_reg[0] <= MSW'(NRMW - 1) - lz_reg[7];
        fr_reg[0] <= '0;
        for (int j = 1; j <= FRW; j++)
        begin
            y_reg[j]  <= sq_w[j-1][MANW-1:0];
            fr_reg[j] <= {fr_reg[j-1][FRW-2:0], sq_w[j-1][MANW]};
            ms_reg[j] <= ms_reg[j-1];
        end
        lhd_reg <= {ms_reg[FRW], fr_reg[FRW], 1'b0};
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            cov.adj[k] = adj_reg[k];
        end
        cov.det      = det_reg;
        cov.lhd      = lhd_reg;
        cov.singular = det_reg[DW-1] || (det_reg == '0);
    end

endmodule

>>> rtl/gpw_div.sv
module gpw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  logic [gpw_pkg::NUMW-1:0]    num,
    input  logic                        qneg,
    input  logic [gpw_pkg::DW-1:0]      det,
    output logic                        out_vld,
    output logic [gpw_pkg::QMW-1:0]     qm,
    output logic                        qneg_out
);
    import gpw_pkg::*;

    localparam int NSTG = QMW;
    localparam logic [QMW-1:0] QM_ONE = QMW'(1);
    localparam logic [QMW-1:0] QM_MAX = QM_ONE << (QMW - 1);

    logic [NUMW-1:0] dext;
    logic [NUMW-1:0] rem_reg [NSTG+1];
    logic [QMW-1:0]  quo_reg [NSTG+1];
    logic            sat_reg [NSTG+1];
    logic            neg_reg [NSTG+1];
    logic            vld_reg [NSTG+1];
    logic [QMW-1:0]  qm_reg;
    logic            qneg_reg;
    logic            out_vld_reg;

    assign dext = NUMW'(det);

    // Restoring division, one quotient bit per stage, most significant first.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        quo_reg[0] <= '0;
        sat_reg[0] <= num >= (dext << NSTG);
        neg_reg[0] <= qneg;
        for (int j = 1; j <= NSTG; j++)
        begin
            if (rem_reg[j-1] >= (dext << (NSTG - j)))
            begin
                rem_reg[j] <= rem_reg[j-1] - (dext << (NSTG - j));
                quo_reg[j] <= quo_reg[j-1] | (QM_ONE << (NSTG - j));
            end
            else
            begin
                rem_reg[j] <= rem_reg[j-1];
                quo_reg[j] <= quo_reg[j-1];
            end
            sat_reg[j] <= sat_reg[j-1];
            neg_reg[j] <= neg_reg[j-1];
        end
        qm_reg   <= (sat_reg[NSTG] || quo_reg[NSTG] > QM_MAX) ? QM_MAX : quo_reg[NSTG];
        qneg_reg <= neg_reg[NSTG];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= NSTG; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int j = 1; j <= NSTG; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
            out_vld_reg <= vld_reg[NSTG];
        end
    end

    assign out_vld  = out_vld_reg;
    assign qm       = qm_reg;
    assign qneg_out = qneg_reg;

endmodule

>>> rtl/gpw_term.sv
module gpw_term #(
    parameter int DIVK = 1
) (
    input  logic                       clk,
    input  logic [gpw_pkg::TRW-1:0]    term_in,
    input  logic [gpw_pkg::XW-1:0]     x_in,
    input  logic [gpw_pkg::SUMW-1:0]   sum_in,
    output logic [gpw_pkg::TRW-1:0]    term_out,
    output logic [gpw_pkg::XW-1:0]     x_out,
    output logic [gpw_pkg::SUMW-1:0]   sum_out
);
    import gpw_pkg::*;

    localparam int RW = TRW + 1;
    localparam int KW = TRW + 4;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << TRW) / DIVK);

    logic [TRW+XW-1:0] prod_a;
    logic [TRW+RW-1:0] prod_b;
    logic [KW-1:0]     rem_c;
    logic [TRW-1:0]    quo_c;
    logic [TRW-1:0]    va_reg, vb_reg, qb_reg, term_reg;
    logic [XW-1:0]     xa_reg, xb_reg, x_reg;
    logic [SUMW-1:0]   sa_reg, sb_reg, sum_reg;

    assign prod_a = (TRW+XW)'(term_in) * (TRW+XW)'(x_in);
    assign prod_b = (TRW+RW)'(va_reg) * (TRW+RW)'(RECIP);
    // The reciprocal estimate is at most one short; the remainder corrects it.
    assign rem_c  = KW'(vb_reg) - KW'(qb_reg) * KW'(DIVK);
    assign quo_c  = qb_reg + TRW'(rem_c >= KW'(DIVK));

    always_ff @(posedge clk)
    begin
        va_reg   <= prod_a[TRW+XW-1:XW];
        xa_reg   <= x_in;
        sa_reg   <= sum_in;
        qb_reg   <= prod_b[TRW+TRW-1:TRW];
        vb_reg   <= va_reg;
        xb_reg   <= xa_reg;
        sb_reg   <= sa_reg;
        term_reg <= quo_c;
        x_reg    <= xb_reg;
        sum_reg  <= sb_reg + SUMW'(quo_c);
    end

    assign term_out = term_reg;
    assign x_out    = x_reg;
    assign sum_out  = sum_reg;

endmodule

>>> rtl/gpw_exp.sv
module gpw_exp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [gpw_pkg::QMW-1:0]    qm,
    input  logic                       qneg,
    input  logic [gpw_pkg::LHW-1:0]    lhd,
    output logic                       out_vld,
    output logic [gpw_pkg::WW-1:0]     weight,
    output logic                       saturated
);
    import gpw_pkg::*;

    localparam logic signed [LW-1:0] OV_LIM = 48'sd137438953472;
    localparam logic signed [LW-1:0] UF_LIM = -48'sd171798691840;
    localparam logic [LW-1:0]        BIAS   = 48'd171798691840;
    localparam int PW1  = QMW + 28;
    localparam int SIDW = 3 + NW;

    logic [PW1-1:0]         prod_t;
    logic [2*XW-1:0]        prod_x;
    logic [LW-1:0]          lb;
    logic [T1W-1:0]         t1_reg;
    logic                   neg1_reg;
    logic signed [LW-1:0]   l_reg;
    logic                   ov_reg, uf_reg, ov4_reg, uf4_reg;
    logic [NW-1:0]          n_reg, n4_reg;
    logic [XW-1:0]          frac_reg, x_reg;
    logic [3:0]             vld_reg;
    logic [TRW-1:0]         tm [NTERM+1];
    logic [XW-1:0]          xs [NTERM+1];
    logic [SUMW-1:0]        sm [NTERM+1];
    logic [SIDW-1:0]        side;
    logic                   s_vld, s_ov, s_uf;
    logic [NW-1:0]          s_n, s_nneg;
    logic [WW-1:0]          wide;
    logic [WW-1:0]          w_reg;
    logic                   sat_reg, vld_out_reg;

    assign prod_t = PW1'(qm) * PW1'(LOG2E_HALF);
    assign lb     = l_reg + BIAS;
    assign prod_x = (2*XW)'(frac_reg) * (2*XW)'(LN2_FRAC);

    always_ff @(posedge clk)
    begin
        t1_reg   <= prod_t[PW1-1:20];
        neg1_reg <= qneg;
        l_reg    <= KCONST - LW'(lhd) + (neg1_reg ? LW'(t1_reg) : -LW'(t1_reg));
        ov_reg   <= l_reg >= OV_LIM;
        uf_reg   <= l_reg < UF_LIM;
        n_reg    <= NW'(lb[38:32]) - NW'(40);
        frac_reg <= lb[31:0];
        x_reg    <= prod_x[2*XW-1:XW];
        ov4_reg  <= ov_reg;
        uf4_reg  <= uf_reg;
        n4_reg   <= n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    assign tm[0] = TRW'(1) << 32;
    assign xs[0] = x_reg;
    assign sm[0] = SUMW'(1) << 32;

    for (genvar k = 0; k < NTERM; k++)
    begin : g_term
        gpw_term #(.DIVK(k + 1)) u_term (
            .clk      (clk),
            .term_in  (tm[k]),
            .x_in     (xs[k]),
            .sum_in   (sm[k]),
            .term_out (tm[k+1]),
            .x_out    (xs[k+1]),
            .sum_out  (sm[k+1])
        );
    end

    gpw_dly #(.W(SIDW), .N(3 * NTERM)) u_side (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({vld_reg[3], ov4_reg, uf4_reg, n4_reg}),
        .dout  (side)
    );

    assign {s_vld, s_ov, s_uf, s_n} = side;
    assign s_nneg = -s_n;
    assign wide   = WW'(sm[NTERM]);

    always_ff @(posedge clk)
    begin
        if (s_ov)
        begin
            w_reg <= '1;
        end
        else if (s_uf)
        begin
            w_reg <= '0;
        end
        else if (!s_n[NW-1])
        begin
            w_reg <= wide << s_n[4:0];
        end
        else
        begin
            w_reg <= wide >> s_nneg[5:0];
        end
        sat_reg <= s_ov;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_out_reg <= s_vld;
        end
    end

    assign out_vld   = vld_out_reg;
    assign weight    = w_reg;
    assign saturated = sat_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gpw_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    gpw_req_t            request;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CW-1:0]       cfg_data;
    logic                done;
    gpw_rsp_t            result;

    logic [CW-1:0]       cov_reg [6];
    gpw_rsp_t            weight_q [$];
    int                  mismatches;
    int                  idle_pct;

    gaussian_pose_weight_3d_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic gpw_rsp_t density_of(input gpw_req_t r);
        logic signed [191:0] a, b, c, e, f, g, dx, dy, dt;
        logic signed [191:0] a00, a01, a02, a11, a12, a22, det, v0, v1, v2, qn, num;
        logic [63:0]         qm, t1, y, fr, lhd, lb, x, term, sum;
        logic signed [63:0]  lval;
        logic                qneg;
        int                  msb, n;
        gpw_rsp_t            res;
        res = '0;
        a = {160'd0, cov_reg[CFG_XX]};
        b = $signed(cov_reg[CFG_XY]);
        c = $signed(cov_reg[CFG_XT]);
        e = {160'd0, cov_reg[CFG_YY]};
        f = $signed(cov_reg[CFG_YT]);
        g = {160'd0, cov_reg[CFG_TT]};
        dx = $signed(r.particle_x) - $signed(r.ref_x);
        dy = $signed(r.particle_y) - $signed(r.ref_y);
        dt = $signed(r.particle_heading) - $signed(r.ref_heading);
        a00 = e * g - f * f;
        a01 = c * f - b * g;
        a02 = b * f - c * e;
        a11 = a * g - c * c;
        a12 = b * c - a * f;
        a22 = a * e - b * b;
        det = a00 * a + a01 * b + a02 * c;
        if (det <= 0)
        begin
            res.singular = 1'b1;
            return res;
        end
        v0 = a00 * dx + a01 * dy + a02 * dt;
        v1 = a01 * dx + a11 * dy + a12 * dt;
        v2 = a02 * dx + a12 * dy + a22 * dt;
        qn = v0 * dx + v1 * dy + v2 * dt;
        qneg = qn < 0;
        num = qneg ? -qn : qn;
        num = num << 8;
        if (num >= (det << 34))
        begin
            qm = 64'd1 << 33;
        end
        else
        begin
            qm = 64'(num / det);
            if (qm > (64'd1 << 33))
            begin
                qm = 64'd1 << 33;
            end
        end
        t1 = (qm * 64'(LOG2E_HALF)) >> 20;
        msb = -1;
        for (int i = 191; i >= 0; i--)
        begin
            if (msb < 0 && det[i])
            begin
                msb = i;
            end
        end
        if (msb >= 30)
        begin
            y = 64'(det >> (msb - 30));
        end
        else
        begin
            y = 64'(det << (30 - msb));
        end
        fr = '0;
        for (int i = 0; i < 30; i++)
        begin
            y = (y * y) >> 30;
            fr = fr << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                fr = fr | 64'd1;
            end
        end
        lhd = ((64'(msb) << 32) | (fr << 2)) >> 1;
        lval = KCONST;
        lval = lval - $signed(lhd);
        if (qneg)
        begin
            lval = lval + $signed(t1);
        end
        else
        begin
            lval = lval - $signed(t1);
        end
        if (lval >= (64'sd32 <<< 32))
        begin
            res.weight = '1;
            res.saturated = 1'b1;
            return res;
        end
        if (lval < -(64'sd40 <<< 32))
        begin
            return res;
        end
        lb = $unsigned(lval + (64'sd40 <<< 32));
        n = int'(lb >> 32) - 40;
        x = (64'(lb[31:0]) * 64'(LN2_FRAC)) >> 32;
        term = 64'd1 << 32;
        sum = term;
        for (int i = 1; i <= NTERM; i++)
        begin
            term = ((term * x) >> 32) / 64'(i);
            sum = sum + term;
        end
        res.weight = (n >= 0) ? (sum << n) : (sum >> (-n));
        return res;
    endfunction

    always @(posedge clk)
    begin
        gpw_rsp_t want;
        if (rst_n && done)
        begin
            if (weight_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result: weight %h singular %b saturated %b",
                             result.weight, result.singular, result.saturated);
                end
            end
            else
            begin
                want = weight_q.pop_front();
                if (result.weight !== want.weight || result.singular !== want.singular
                    || result.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.weight, want.singular, want.saturated,
                                 result.weight, result.singular, result.saturated);
                    end
                end
            end
        end
    end

    task automatic send_pose(input gpw_req_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        request = r;
        while (busy)
        begin
            @(negedge clk);
        end
        weight_q = {weight_q, density_of(r)};
        @(posedge clk);
    endtask

    task automatic drain_requests();
        @(negedge clk);
        start = 1'b0;
        while (weight_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_cov(input cfg_idx_t idx, input logic [CW-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        cov_reg[idx] = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_cov(input logic [CW-1:0] xx, input logic [CW-1:0] xy,
                            input logic [CW-1:0] xt, input logic [CW-1:0] yy,
                            input logic [CW-1:0] yt, input logic [CW-1:0] tt);
        drain_requests();
        repeat (100) @(negedge clk);
        write_cov(CFG_XX, xx);
        write_cov(CFG_XY, xy);
        write_cov(CFG_XT, xt);
        write_cov(CFG_YY, yy);
        write_cov(CFG_YT, yt);
        write_cov(CFG_TT, tt);
    endtask

    function automatic gpw_req_t pose_pair(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                           input logic [CW-1:0] ph, input logic [CW-1:0] rx,
                                           input logic [CW-1:0] ry, input logic [CW-1:0] rh);
        gpw_req_t r;
        r.particle_x = px;
        r.particle_y = py;
        r.particle_heading = ph;
        r.ref_x = rx;
        r.ref_y = ry;
        r.ref_heading = rh;
        return r;
    endfunction

    function automatic logic [CW-1:0] near_offset();
        int sh;
        logic [CW-1:0] v;
        sh = $urandom_range(0, 22);
        v = $urandom_range(0, (1 << sh) - 1);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    function automatic gpw_req_t random_pose();
        gpw_req_t r;
        r.ref_x = $urandom();
        r.ref_y = $urandom();
        r.ref_heading = $urandom();
        if ($urandom_range(0, 99) < 15)
        begin
            r.particle_x = $urandom();
            r.particle_y = $urandom();
            r.particle_heading = $urandom();
        end
        else
        begin
            r.particle_x = r.ref_x + near_offset();
            r.particle_y = r.ref_y + near_offset();
            r.particle_heading = r.ref_heading + near_offset();
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] random_variance();
        case ($urandom_range(0, 5))
            0: return 32'h0001_0000;
            1: return $urandom_range(1, 32'h000f_ffff);
            2: return $urandom();
            3: return 32'd1;
            4: return 32'hffff_ffff;
            default: return $urandom_range(32'h0000_1000, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic [CW-1:0] random_cross(input logic [CW-1:0] p, input logic [CW-1:0] q);
        longint lim;
        longint v;
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom();
        end
        lim = ((p < q) ? p : q) / 3;
        if (lim > 32'h7fff_ffff)
        begin
            lim = 32'h7fff_ffff;
        end
        v = longint'($urandom()) % (lim + 1);
        return $urandom_range(0, 1) ? 32'(v) : 32'(-v);
    endfunction

    task automatic test_reset_defaults();
        send_pose(pose_pair(0, 0, 0, 0, 0, 0));
        send_pose(pose_pair(32'h0001_0000, 0, 0, 0, 0, 0));
        send_pose(pose_pair(0, 32'hffff_0000, 32'h0000_8000, 0, 0, 0));
        send_pose(pose_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_pose(pose_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_pose(pose_pair(0, 0, 32'h0006_487f, 0, 0, 32'hfff9_b781));
        send_pose(pose_pair(32'h0002_8000, 32'h0001_8000, 0, 0, 0, 0));
        send_pose(pose_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                            32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    endtask

    task automatic test_covariance_cases();
        load_cov(0, 0, 0, 0, 0, 0);
        send_pose(pose_pair(0, 0, 0, 0, 0, 0));
        send_pose(pose_pair(32'h0001_0000, 0, 0, 0, 0, 0));
        load_cov(32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000);
        send_pose(pose_pair(32'h0000_1000, 0, 0, 0, 0, 0));
        load_cov(32'h0001_0000, 32'h0004_0000, 0, 32'h0001_0000, 0, 32'h0001_0000);
        send_pose(pose_pair(32'h0001_0000, 32'hffff_0000, 0, 0, 0, 0));
        send_pose(pose_pair(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
        load_cov(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
        send_pose(pose_pair(0, 0, 0, 0, 0, 0));
        send_pose(pose_pair(32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff));
        load_cov(32'd1, 0, 0, 32'd1, 0, 32'd1);
        send_pose(pose_pair(0, 0, 0, 0, 0, 0));
        send_pose(pose_pair(32'd1, 0, 0, 0, 0, 0));
        load_cov(32'h0000_0100, 32'h0000_0080, 32'hffff_ff80,
                 32'h0000_0100, 32'h0000_0040, 32'h0000_0100);
        send_pose(pose_pair(32'h0000_0010, 32'h0000_0020, 32'h0000_0008, 0, 0, 0));
    endtask

    task automatic test_random_stream();
        logic [CW-1:0] xx, yy, tt;
        int pcts [4] = '{0, 46, 0, 37};
        for (int ph = 0; ph < 12; ph++)
        begin
            xx = random_variance();
            yy = random_variance();
            tt = random_variance();
            idle_pct = 0;
            load_cov(xx, random_cross(xx, yy), random_cross(xx, tt), yy,
                     random_cross(yy, tt), tt);
            idle_pct = pcts[ph % 4];
            for (int k = 0; k < 110; k++)
            begin
                send_pose(random_pose());
                if (k == 55 && ph == 5)
                begin
                    drain_requests();
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_XX;
        cfg_data = '0;
        mismatches = 0;
        idle_pct = 0;
        cov_reg[CFG_XX] = 32'h0001_0000;
        cov_reg[CFG_XY] = '0;
        cov_reg[CFG_XT] = '0;
        cov_reg[CFG_YY] = 32'h0001_0000;
        cov_reg[CFG_YT] = '0;
        cov_reg[CFG_TT] = 32'h0001_0000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_covariance_cases();
        test_random_stream();

        drain_requests();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && weight_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> gaussian_pose_weight_3d_top.f
rtl/gpw_pkg.sv
rtl/gpw_dly.sv
rtl/gpw_mul.sv
rtl/gpw_cov.sv
rtl/gpw_div.sv
rtl/gpw_term.sv
rtl/gpw_exp.sv
rtl/gaussian_pose_weight_3d_top.sv
verif/testbench.sv
